// ----- rtl/fbpw_pkg.sv -----
// ----------------------------------------------------------------------------
// fbpw_pkg
// Shared register map, field widths, reset values and constants for the
// framebuffer pixel writer and its port checker.
// ----------------------------------------------------------------------------
`default_nettype none

package fbpw_pkg;

    // Field widths.
    localparam int unsigned COORD_W  = 16;
    localparam int unsigned RGB_W    = 24;
    localparam int unsigned DIM_W    = 13;
    localparam int unsigned PITCH_W  = 17;
    localparam int unsigned LAYOUT_W = 10;
    localparam int unsigned OFFSET_W = 28;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned BE_W     = 4;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 17;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FOUR_BYTE_MODE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RED_LAYOUT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_LAYOUT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_LAYOUT    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE         = 3'd7;

    // Register reset values.
    localparam logic [DIM_W-1:0]    RST_FRAME_WIDTH  = 13'd1024;
    localparam logic [DIM_W-1:0]    RST_FRAME_HEIGHT = 13'd768;
    localparam logic [PITCH_W-1:0]  RST_ROW_PITCH    = 17'd4096;
    localparam logic                RST_FOUR_BYTE    = 1'b1;
    localparam logic [LAYOUT_W-1:0] RST_RED_LAYOUT   = 10'd272;
    localparam logic [LAYOUT_W-1:0] RST_GREEN_LAYOUT = 10'd264;
    localparam logic [LAYOUT_W-1:0] RST_BLUE_LAYOUT  = 10'd256;
    localparam logic                RST_ENABLE       = 1'b0;

    // Largest visible frame dimension; larger settings saturate to it.
    localparam logic [DIM_W-1:0] MAX_DIM = 13'd4096;

    // Layout field split.
    localparam int unsigned POS_W      = 5;
    localparam int unsigned LAY_BITS_W = 5;

    // Default layout used when any channel width is zero.
    localparam logic [LAY_BITS_W-1:0] DEF_CHAN_BITS = 5'd8;
    localparam logic [POS_W-1:0]      DEF_RED_POS   = 5'd16;
    localparam logic [POS_W-1:0]      DEF_GREEN_POS = 5'd8;
    localparam logic [POS_W-1:0]      DEF_BLUE_POS  = 5'd0;

    // Rounding bias and division by 255 as a reciprocal multiply:
    // floor(n * RECIP / 2^32) equals n / 255 for every n below 2^24.
    localparam int unsigned CHAN_W       = 8;
    localparam logic [7:0]  ROUND_BIAS   = 8'd127;
    localparam int unsigned RECIP_W      = 25;
    localparam logic [RECIP_W-1:0] DIV255_RECIP = 25'd16843010;
    localparam int unsigned DIV255_SHIFT = 32;

    // Byte enables per pixel format.
    localparam logic [BE_W-1:0] BE_32BPP = 4'hF;
    localparam logic [BE_W-1:0] BE_24BPP = 4'h7;

endpackage

`default_nettype wire

// ----- rtl/framebuffer_pixel_writer.sv -----
// ----------------------------------------------------------------------------
// framebuffer_pixel_writer
// Turns one pixel write (x, y, RGB888 color) into one framebuffer memory
// write: byte offset, packed pixel word and byte enables.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries x, y and a 24-bit color.
//   Output channel (o_out_valid / i_out_stall) carries write_valid, the byte
//   offset, the packed word and the byte enables, one result per item.
//   An item is taken when valid is high and stall is low at a clock edge.
//   An item passes one input register, then the color scaling, packing
//   and offset multiply feed the result register. One item per cycle is
//   sustained while the receiver does not stall; the per-channel reciprocal
//   multiply for the divide-by-255 and the y * pitch multiply set the cycle time.
//   When the receiver stalls, the result register holds and the input
//   register fills; o_in_stall rises only once both are occupied.
//   Configuration writes through i_cfg_we / i_cfg_index / i_cfg_data take effect
//   at once; the user must make them while no item is in flight; the block does not check it.
//   Synchronous reset empties both registers and restores the default
//   1024x768, 32-bit, 8/8/8 at 16/8/0 layout with writes disabled.
//   A disabled block or a clipped pixel gives a result of all zeros.
// ----------------------------------------------------------------------------
`default_nettype none

module framebuffer_pixel_writer #(
    parameter int unsigned MAX_CHANNEL_BITS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Configuration write port.
    input  wire logic                                i_cfg_we,
    input  wire logic [fbpw_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [fbpw_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // Input channel.
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [fbpw_pkg::COORD_W-1:0]        i_x_pos,
    input  wire logic [fbpw_pkg::COORD_W-1:0]        i_y_pos,
    input  wire logic [fbpw_pkg::RGB_W-1:0]          i_color_rgb,
    // Output channel.
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic                                     o_write_valid,
    output logic [fbpw_pkg::OFFSET_W-1:0]            o_byte_offset,
    output logic [fbpw_pkg::WORD_W-1:0]              o_pixel_word,
    output logic [fbpw_pkg::BE_W-1:0]                o_byte_enables
);

    // Width of a channel width value, of the numerator before the divide by
    // 255 and of its product with the reciprocal.
    localparam int unsigned WW    = $clog2(MAX_CHANNEL_BITS + 1);
    localparam int unsigned NUM_W = fbpw_pkg::CHAN_W + MAX_CHANNEL_BITS;
    localparam int unsigned PROD_W = NUM_W + fbpw_pkg::RECIP_W;
    localparam logic [WW-1:0] MAX_BITS = WW'(MAX_CHANNEL_BITS);

    // Scale an 8-bit channel to w bits with rounding: (v*(2^w-1)+127)/255.
    function automatic logic [MAX_CHANNEL_BITS-1:0] scale_chan(
        input logic [fbpw_pkg::CHAN_W-1:0] v,
        input logic [WW-1:0]               w
    );
        logic [NUM_W-1:0]  num;
        logic [PROD_W-1:0] prod;
        num  = (NUM_W'(v) << w) - NUM_W'(v) + NUM_W'(fbpw_pkg::ROUND_BIAS);
        prod = PROD_W'(num) * PROD_W'(fbpw_pkg::DIV255_RECIP);
        return prod[fbpw_pkg::DIV255_SHIFT +: MAX_CHANNEL_BITS];
    endfunction

    // Saturate a layout width field to the channel limit.
    function automatic logic [WW-1:0] clamp_bits(
        input logic [fbpw_pkg::LAY_BITS_W-1:0] f
    );
        logic [WW-1:0] res;
        if (32'(f) > MAX_CHANNEL_BITS) begin
            res = MAX_BITS;
        end else begin
            res = WW'(f);
        end
        return res;
    endfunction

    // Configuration registers.
    logic [fbpw_pkg::DIM_W-1:0]    r_frame_width;
    logic [fbpw_pkg::DIM_W-1:0]    r_frame_height;
    logic [fbpw_pkg::PITCH_W-1:0]  r_row_pitch;
    logic                          r_four_byte;
    logic [fbpw_pkg::LAYOUT_W-1:0] r_red_layout;
    logic [fbpw_pkg::LAYOUT_W-1:0] r_green_layout;
    logic [fbpw_pkg::LAYOUT_W-1:0] r_blue_layout;
    logic                          r_enable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= fbpw_pkg::RST_FRAME_WIDTH;
            r_frame_height <= fbpw_pkg::RST_FRAME_HEIGHT;
            r_row_pitch    <= fbpw_pkg::RST_ROW_PITCH;
            r_four_byte    <= fbpw_pkg::RST_FOUR_BYTE;
            r_red_layout   <= fbpw_pkg::RST_RED_LAYOUT;
            r_green_layout <= fbpw_pkg::RST_GREEN_LAYOUT;
            r_blue_layout  <= fbpw_pkg::RST_BLUE_LAYOUT;
            r_enable       <= fbpw_pkg::RST_ENABLE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fbpw_pkg::REG_FRAME_WIDTH:
                    r_frame_width <= i_cfg_data[fbpw_pkg::DIM_W-1:0];
                fbpw_pkg::REG_FRAME_HEIGHT:
                    r_frame_height <= i_cfg_data[fbpw_pkg::DIM_W-1:0];
                fbpw_pkg::REG_ROW_PITCH:
                    r_row_pitch <= i_cfg_data[fbpw_pkg::PITCH_W-1:0];
                fbpw_pkg::REG_FOUR_BYTE_MODE:
                    r_four_byte <= i_cfg_data[0];
                fbpw_pkg::REG_RED_LAYOUT:
                    r_red_layout <= i_cfg_data[fbpw_pkg::LAYOUT_W-1:0];
                fbpw_pkg::REG_GREEN_LAYOUT:
                    r_green_layout <= i_cfg_data[fbpw_pkg::LAYOUT_W-1:0];
                fbpw_pkg::REG_BLUE_LAYOUT:
                    r_blue_layout <= i_cfg_data[fbpw_pkg::LAYOUT_W-1:0];
                fbpw_pkg::REG_ENABLE:
                    r_enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Pipeline control: the input register moves forward whenever the
    // result register is empty or being drained.
    logic r_in_valid;
    logic r_out_valid;
    logic s1_advance;
    logic in_accept;

    assign s1_advance = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !s1_advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Input register.
    logic [fbpw_pkg::COORD_W-1:0] r_x;
    logic [fbpw_pkg::COORD_W-1:0] r_y;
    logic [fbpw_pkg::RGB_W-1:0]   r_rgb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_x   <= i_x_pos;
            r_y   <= i_y_pos;
            r_rgb <= i_color_rgb;
        end
    end

    // Clipping against the saturated frame size.
    logic [fbpw_pkg::DIM_W-1:0] dim_w_eff;
    logic [fbpw_pkg::DIM_W-1:0] dim_h_eff;
    logic                       visible;

    always_comb begin
        dim_w_eff = (r_frame_width > fbpw_pkg::MAX_DIM) ? fbpw_pkg::MAX_DIM : r_frame_width;
        dim_h_eff = (r_frame_height > fbpw_pkg::MAX_DIM) ? fbpw_pkg::MAX_DIM : r_frame_height;
        visible   = r_enable
                    && (r_x < fbpw_pkg::COORD_W'(dim_w_eff))
                    && (r_y < fbpw_pkg::COORD_W'(dim_h_eff));
    end

    // Channel layout decode, with the default layout when any width is zero.
    logic [WW-1:0]             red_bits;
    logic [WW-1:0]             green_bits;
    logic [WW-1:0]             blue_bits;
    logic [fbpw_pkg::POS_W-1:0] red_pos;
    logic [fbpw_pkg::POS_W-1:0] green_pos;
    logic [fbpw_pkg::POS_W-1:0] blue_pos;

    always_comb begin
        red_bits   = clamp_bits(r_red_layout[fbpw_pkg::POS_W +: fbpw_pkg::LAY_BITS_W]);
        green_bits = clamp_bits(r_green_layout[fbpw_pkg::POS_W +: fbpw_pkg::LAY_BITS_W]);
        blue_bits  = clamp_bits(r_blue_layout[fbpw_pkg::POS_W +: fbpw_pkg::LAY_BITS_W]);
        red_pos    = r_red_layout[fbpw_pkg::POS_W-1:0];
        green_pos  = r_green_layout[fbpw_pkg::POS_W-1:0];
        blue_pos   = r_blue_layout[fbpw_pkg::POS_W-1:0];
        if (red_bits == '0 || green_bits == '0 || blue_bits == '0) begin
            red_bits   = WW'(fbpw_pkg::DEF_CHAN_BITS);
            green_bits = WW'(fbpw_pkg::DEF_CHAN_BITS);
            blue_bits  = WW'(fbpw_pkg::DEF_CHAN_BITS);
            red_pos    = fbpw_pkg::DEF_RED_POS;
            green_pos  = fbpw_pkg::DEF_GREEN_POS;
            blue_pos   = fbpw_pkg::DEF_BLUE_POS;
        end
    end

    // Scale each channel, place it, and merge into the 32-bit word.
    logic [MAX_CHANNEL_BITS-1:0] red_scaled;
    logic [MAX_CHANNEL_BITS-1:0] green_scaled;
    logic [MAX_CHANNEL_BITS-1:0] blue_scaled;
    logic [fbpw_pkg::WORD_W-1:0] packed_word;

    always_comb begin
        red_scaled   = scale_chan(r_rgb[23:16], red_bits);
        green_scaled = scale_chan(r_rgb[15:8], green_bits);
        blue_scaled  = scale_chan(r_rgb[7:0], blue_bits);
        packed_word  = (fbpw_pkg::WORD_W'(red_scaled) << red_pos)
                     | (fbpw_pkg::WORD_W'(green_scaled) << green_pos)
                     | (fbpw_pkg::WORD_W'(blue_scaled) << blue_pos);
    end

    // Byte offset: y * pitch + x * (4 or 3), wrapping at 28 bits.
    logic [fbpw_pkg::COORD_W+fbpw_pkg::PITCH_W-1:0] row_offset;
    logic [fbpw_pkg::OFFSET_W-1:0]                  col_offset;
    logic [fbpw_pkg::OFFSET_W-1:0]                  pixel_offset;

    always_comb begin
        row_offset = (fbpw_pkg::COORD_W + fbpw_pkg::PITCH_W)'(r_y)
                   * (fbpw_pkg::COORD_W + fbpw_pkg::PITCH_W)'(r_row_pitch);
        if (r_four_byte) begin
            col_offset = fbpw_pkg::OFFSET_W'(r_x) << 2;
        end else begin
            col_offset = (fbpw_pkg::OFFSET_W'(r_x) << 1) + fbpw_pkg::OFFSET_W'(r_x);
        end
        pixel_offset = row_offset[fbpw_pkg::OFFSET_W-1:0] + col_offset;
    end

    // Result register.
    logic                          n_write_valid;
    logic [fbpw_pkg::OFFSET_W-1:0] n_byte_offset;
    logic [fbpw_pkg::WORD_W-1:0]   n_pixel_word;
    logic [fbpw_pkg::BE_W-1:0]     n_byte_enables;
    logic                          r_write_valid;
    logic [fbpw_pkg::OFFSET_W-1:0] r_byte_offset;
    logic [fbpw_pkg::WORD_W-1:0]   r_pixel_word;
    logic [fbpw_pkg::BE_W-1:0]     r_byte_enables;

    always_comb begin
        n_write_valid  = 1'b0;
        n_byte_offset  = '0;
        n_pixel_word   = '0;
        n_byte_enables = '0;
        if (visible) begin
            n_write_valid  = 1'b1;
            n_byte_offset  = pixel_offset;
            n_pixel_word   = packed_word;
            n_byte_enables = r_four_byte ? fbpw_pkg::BE_32BPP : fbpw_pkg::BE_24BPP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid && s1_advance) begin
            r_write_valid  <= n_write_valid;
            r_byte_offset  <= n_byte_offset;
            r_pixel_word   <= n_pixel_word;
            r_byte_enables <= n_byte_enables;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_write_valid  = r_write_valid;
    assign o_byte_offset  = r_byte_offset;
    assign o_pixel_word   = r_pixel_word;
    assign o_byte_enables = r_byte_enables;

endmodule

`default_nettype wire

// ----- rtl/fbpw_checker.sv -----
// ----------------------------------------------------------------------------
// fbpw_checker
// Port-level checks for the framebuffer pixel writer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpw_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_in_valid,
    input wire logic                            o_in_stall,
    input wire logic                            o_out_valid,
    input wire logic                            i_out_stall,
    input wire logic                            o_write_valid,
    input wire logic [fbpw_pkg::OFFSET_W-1:0]   o_byte_offset,
    input wire logic [fbpw_pkg::WORD_W-1:0]     o_pixel_word,
    input wire logic [fbpw_pkg::BE_W-1:0]       o_byte_enables
);

    // A stalled result keeps its valid and its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_write_valid) && $stable(o_byte_offset)
             && $stable(o_pixel_word) && $stable(o_byte_enables)))
        else $error("stalled result changed");

    // A suppressed write carries an all-zero payload.
    a_suppressed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_write_valid) |->
            (o_byte_offset == '0 && o_pixel_word == '0 && o_byte_enables == '0))
        else $error("suppressed write has nonzero payload");

    // A real write enables either three or four bytes.
    a_byte_enables: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_write_valid) |->
            (o_byte_enables == fbpw_pkg::BE_32BPP || o_byte_enables == fbpw_pkg::BE_24BPP))
        else $error("bad byte enables on a write");

    // An accepted item reaches the output through the input and result registers
    // if the output drains in the cycle after acceptance.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) ##1 (!o_out_valid || !i_out_stall) |=> o_out_valid)
        else $error("accepted item did not reach the output");

endmodule

bind framebuffer_pixel_writer fbpw_checker u_fbpw_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_write_valid  (o_write_valid),
    .o_byte_offset  (o_byte_offset),
    .o_pixel_word   (o_pixel_word),
    .o_byte_enables (o_byte_enables)
);

`default_nettype wire

// ----- test/framebuffer_pixel_writer_checker.sv -----
// ----------------------------------------------------------------------------
// framebuffer_pixel_writer_checker
// Watches the register port and both item channels of the framebuffer pixel
// writer. It keeps its own copy of the registers, predicts the memory write
// for every accepted pixel and compares each result with the oldest
// prediction, field by field.
// ----------------------------------------------------------------------------

module framebuffer_pixel_writer_checker
    import fbpw_pkg::*;
#(
    parameter int unsigned MAX_CHANNEL_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Register port.
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Pixel channel.
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [COORD_W-1:0]    i_x_pos,
    input  logic [COORD_W-1:0]    i_y_pos,
    input  logic [RGB_W-1:0]      i_color_rgb,
    // Memory write channel.
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic                  i_write_valid,
    input  logic [OFFSET_W-1:0]   i_byte_offset,
    input  logic [WORD_W-1:0]     i_pixel_word,
    input  logic [BE_W-1:0]       i_byte_enables,
    // Progress and error counts for the testbench top.
    output int unsigned           o_pending,
    output int unsigned           o_mismatches,
    output int unsigned           o_checked,
    output int unsigned           o_written
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                write_valid;
        logic [OFFSET_W-1:0] byte_offset;
        logic [WORD_W-1:0]   pixel_word;
        logic [BE_W-1:0]     byte_enables;
    } pixel_write_t;

    // Local copy of the register file.
    logic [DIM_W-1:0]    frame_width_q;
    logic [DIM_W-1:0]    frame_height_q;
    logic [PITCH_W-1:0]  row_pitch_q;
    logic                four_byte_q;
    logic [LAYOUT_W-1:0] red_layout_q;
    logic [LAYOUT_W-1:0] green_layout_q;
    logic [LAYOUT_W-1:0] blue_layout_q;
    logic                enable_q;

    pixel_write_t expected_writes[$];
    pixel_write_t want;

    initial begin
        o_pending    = 0;
        o_mismatches = 0;
        o_checked    = 0;
        o_written    = 0;
    end

    // Rescale one 8-bit level to the channel width with rounding and move
    // it to its bit position; bits above the word are dropped.
    function automatic logic [WORD_W-1:0] place_scaled(input logic [7:0] level,
                                                       input int unsigned bits,
                                                       input int unsigned shift);
        int unsigned full_scale;
        int unsigned scaled;
        logic [63:0] placed;
        full_scale = (1 << bits) - 1;
        scaled = (level * full_scale + 127) / 255;
        placed = scaled;
        placed = placed << shift;
        return placed[WORD_W-1:0];
    endfunction

    // Channel width from a layout register, saturated to the widest channel.
    function automatic int unsigned channel_bits(input logic [LAYOUT_W-1:0] layout);
        int unsigned bits;
        bits = layout[LAYOUT_W-1:POS_W];
        if (bits > MAX_CHANNEL_BITS) begin
            bits = MAX_CHANNEL_BITS;
        end
        return bits;
    endfunction

    function automatic int unsigned visible_dim(input logic [DIM_W-1:0] dim);
        return (dim > MAX_DIM) ? MAX_DIM : dim;
    endfunction

    // Memory write expected for one pixel under the current registers.
    function automatic pixel_write_t predict_write(input logic [COORD_W-1:0] x,
                                                   input logic [COORD_W-1:0] y,
                                                   input logic [RGB_W-1:0]   rgb);
        pixel_write_t res;
        int unsigned  r_bits, g_bits, b_bits;
        int unsigned  r_pos, g_pos, b_pos;
        logic [63:0]  row_start;
        logic [63:0]  column;
        logic [63:0]  offset;
        res = '0;
        if (!enable_q || x >= visible_dim(frame_width_q) ||
                y >= visible_dim(frame_height_q)) begin
            return res;
        end

        r_bits = channel_bits(red_layout_q);
        g_bits = channel_bits(green_layout_q);
        b_bits = channel_bits(blue_layout_q);
        r_pos  = red_layout_q[POS_W-1:0];
        g_pos  = green_layout_q[POS_W-1:0];
        b_pos  = blue_layout_q[POS_W-1:0];
        // A zero-width channel anywhere falls back to the 8/8/8 layout.
        if (r_bits == 0 || g_bits == 0 || b_bits == 0) begin
            r_bits = DEF_CHAN_BITS;
            g_bits = DEF_CHAN_BITS;
            b_bits = DEF_CHAN_BITS;
            r_pos  = DEF_RED_POS;
            g_pos  = DEF_GREEN_POS;
            b_pos  = DEF_BLUE_POS;
        end

        res.pixel_word = place_scaled(rgb[23:16], r_bits, r_pos)
                       | place_scaled(rgb[15:8], g_bits, g_pos)
                       | place_scaled(rgb[7:0], b_bits, b_pos);

        row_start = y;
        row_start = row_start * row_pitch_q;
        column = x;
        column = column * (four_byte_q ? 4 : 3);
        offset = row_start + column;

        res.write_valid  = 1'b1;
        res.byte_offset  = offset[OFFSET_W-1:0];
        res.byte_enables = four_byte_q ? BE_32BPP : BE_24BPP;
        return res;
    endfunction

    task automatic check_field(input string field, input logic [WORD_W-1:0] expected_val,
                               input logic [WORD_W-1:0] actual_val);
        if (expected_val !== actual_val) begin
            o_mismatches++;
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h",
                     $time, field, expected_val, actual_val);
        end
    endtask

    // Register tracking, prediction on accepted pixels and comparison of
    // accepted results against the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_writes.delete();
            o_pending      <= 0;
            frame_width_q  <= RST_FRAME_WIDTH;
            frame_height_q <= RST_FRAME_HEIGHT;
            row_pitch_q    <= RST_ROW_PITCH;
            four_byte_q    <= RST_FOUR_BYTE;
            red_layout_q   <= RST_RED_LAYOUT;
            green_layout_q <= RST_GREEN_LAYOUT;
            blue_layout_q  <= RST_BLUE_LAYOUT;
            enable_q       <= RST_ENABLE;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_FRAME_WIDTH:    frame_width_q  <= i_cfg_data[DIM_W-1:0];
                    REG_FRAME_HEIGHT:   frame_height_q <= i_cfg_data[DIM_W-1:0];
                    REG_ROW_PITCH:      row_pitch_q    <= i_cfg_data[PITCH_W-1:0];
                    REG_FOUR_BYTE_MODE: four_byte_q    <= i_cfg_data[0];
                    REG_RED_LAYOUT:     red_layout_q   <= i_cfg_data[LAYOUT_W-1:0];
                    REG_GREEN_LAYOUT:   green_layout_q <= i_cfg_data[LAYOUT_W-1:0];
                    REG_BLUE_LAYOUT:    blue_layout_q  <= i_cfg_data[LAYOUT_W-1:0];
                    REG_ENABLE:         enable_q       <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if (i_out_valid && !i_out_stall) begin
                if (expected_writes.size() == 0) begin
                    o_mismatches++;
                    $display("%0t: result with no pixel pending: expected none, %s",
                             $time, "got");
                    $display("    %0d 0x%0h 0x%0h 0x%0h",
                             i_write_valid, i_byte_offset, i_pixel_word,
                             i_byte_enables);
                end else begin
                    want = expected_writes.pop_front();
                    o_checked++;
                    if (want.write_valid) begin
                        o_written++;
                    end
                    check_field("write_valid", want.write_valid, i_write_valid);
                    check_field("byte_offset", want.byte_offset, i_byte_offset);
                    check_field("pixel_word", want.pixel_word, i_pixel_word);
                    check_field("byte_enables", want.byte_enables, i_byte_enables);
                end
            end

            if (i_in_valid && !i_in_stall) begin
                expected_writes.push_back(predict_write(i_x_pos, i_y_pos, i_color_rgb));
            end
            o_pending <= expected_writes.size();
        end
    end

endmodule

// ----- test/framebuffer_pixel_writer_tb.sv -----
// ----------------------------------------------------------------------------
// framebuffer_pixel_writer_tb
// Drives pixel writes into the framebuffer pixel writer under a series of
// register settings and handshake pacing modes. A directed opening covers
// clipping, disabled writes, layout fallback and saturation, high bit
// positions and offset wrap; random phases follow. The checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------

module framebuffer_pixel_writer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fbpw_pkg::*;

    localparam int unsigned CHANNEL_BITS    = 16;
    localparam int unsigned NUM_REGS        = 8;
    localparam int unsigned RANDOM_PHASES   = 12;
    localparam int unsigned ITEMS_PER_PHASE = 138;
    localparam int unsigned SETTLE_CYCLES   = 8;
    localparam int unsigned LIMIT_CYCLES    = 200000;

    typedef enum int unsigned {
        PACE_NONE,
        PACE_SENDER,
        PACE_RECEIVER,
        PACE_BOTH
    } pacing_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [COORD_W-1:0]    x_pos = '0;
    logic [COORD_W-1:0]    y_pos = '0;
    logic [RGB_W-1:0]      color_rgb = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  write_valid;
    logic [OFFSET_W-1:0]   byte_offset;
    logic [WORD_W-1:0]     pixel_word;
    logic [BE_W-1:0]       byte_enables;

    int unsigned pending;
    int unsigned mismatches;
    int unsigned checked;
    int unsigned written;

    // Register values to be programmed, indexed by register.
    logic [CFG_DATA_W-1:0] setup [NUM_REGS];

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned cycles = 0;
    int unsigned settings_applied = 0;

    framebuffer_pixel_writer #(
        .MAX_CHANNEL_BITS(CHANNEL_BITS)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_x_pos        (x_pos),
        .i_y_pos        (y_pos),
        .i_color_rgb    (color_rgb),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_write_valid  (write_valid),
        .o_byte_offset  (byte_offset),
        .o_pixel_word   (pixel_word),
        .o_byte_enables (byte_enables)
    );

    framebuffer_pixel_writer_checker #(
        .MAX_CHANNEL_BITS(CHANNEL_BITS)
    ) write_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_x_pos        (x_pos),
        .i_y_pos        (y_pos),
        .i_color_rgb    (color_rgb),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_write_valid  (write_valid),
        .i_byte_offset  (byte_offset),
        .i_pixel_word   (pixel_word),
        .i_byte_enables (byte_enables),
        .o_pending      (pending),
        .o_mismatches   (mismatches),
        .o_checked      (checked),
        .o_written      (written)
    );

    always #6 clk = ~clk;

    // Receiver stall and the run-time limit.
    always @(posedge clk) begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycles, pending);
            $display("framebuffer_pixel_writer_tb: FAIL");
            $finish;
        end
    end

    task automatic set_pacing(input pacing_t mode);
        case (mode)
            PACE_SENDER: begin
                send_idle_pct  = 71;
                recv_stall_pct = 0;
            end
            PACE_RECEIVER: begin
                send_idle_pct  = 0;
                recv_stall_pct = 71;
            end
            PACE_BOTH: begin
                send_idle_pct  = 9;
                recv_stall_pct = 9;
            end
            default: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    // Stop sending and wait until every predicted result has come back.
    task automatic wait_idle();
        in_valid <= 1'b0;
        do begin
            @(posedge clk);
        end while (pending != 0);
    endtask

    // Program all registers from the setup array once the block is idle.
    task automatic apply_setup();
        wait_idle();
        for (int i = 0; i < NUM_REGS; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= i[CFG_IDX_W-1:0];
            cfg_data  <= setup[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        settings_applied++;
    endtask

    // Offer one pixel, with random idle cycles ahead of it, and hold it
    // until it is accepted.
    task automatic push_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                              input logic [RGB_W-1:0] rgb);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        x_pos     <= x;
        y_pos     <= y;
        color_rgb <= rgb;
        do begin
            @(posedge clk);
        end while (in_stall);
    endtask

    function automatic void load_reset_setup();
        setup[REG_FRAME_WIDTH]    = RST_FRAME_WIDTH;
        setup[REG_FRAME_HEIGHT]   = RST_FRAME_HEIGHT;
        setup[REG_ROW_PITCH]      = RST_ROW_PITCH;
        setup[REG_FOUR_BYTE_MODE] = RST_FOUR_BYTE;
        setup[REG_RED_LAYOUT]     = RST_RED_LAYOUT;
        setup[REG_GREEN_LAYOUT]   = RST_GREEN_LAYOUT;
        setup[REG_BLUE_LAYOUT]    = RST_BLUE_LAYOUT;
        setup[REG_ENABLE]         = RST_ENABLE;
    endfunction

    // Frame dimension: mostly in range, sometimes zero, one or oversized.
    function automatic logic [CFG_DATA_W-1:0] pick_dim();
        case ($urandom_range(0, 29))
            0:       return 0;
            1:       return 1;
            2:       return MAX_DIM;
            3:       return $urandom_range(MAX_DIM + 1, 8191);
            default: return $urandom_range(1, MAX_DIM);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_pitch();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 1;
            2:       return 131071;
            3:       return 65536;
            default: return $urandom_range(0, 131071);
        endcase
    endfunction

    // Channel layout: standard 8-bit, random width and position, or any
    // raw value including zero and oversized widths.
    function automatic logic [CFG_DATA_W-1:0] pick_layout(input logic [POS_W-1:0] std_pos);
        case ($urandom_range(0, 3))
            0:       return {DEF_CHAN_BITS, std_pos};
            1:       return ($urandom_range(1, CHANNEL_BITS) << POS_W) | $urandom_range(0, 31);
            default: return $urandom_range(0, 1023);
        endcase
    endfunction

    function automatic void randomize_setup();
        setup[REG_FRAME_WIDTH]    = pick_dim();
        setup[REG_FRAME_HEIGHT]   = pick_dim();
        setup[REG_ROW_PITCH]      = pick_pitch();
        setup[REG_FOUR_BYTE_MODE] = $urandom_range(0, 1);
        setup[REG_RED_LAYOUT]     = pick_layout(DEF_RED_POS);
        setup[REG_GREEN_LAYOUT]   = pick_layout(DEF_GREEN_POS);
        setup[REG_BLUE_LAYOUT]    = pick_layout(DEF_BLUE_POS);
        setup[REG_ENABLE]         = ($urandom_range(0, 9) != 0);
    endfunction

    // Coordinate: mostly inside the visible range, some on the border and
    // some anywhere in the 16-bit field.
    function automatic logic [COORD_W-1:0] pick_coord(input logic [CFG_DATA_W-1:0] dim);
        int unsigned limit;
        int unsigned pick;
        limit = dim[DIM_W-1:0];
        if (limit > MAX_DIM) begin
            limit = MAX_DIM;
        end
        pick = $urandom_range(0, 19);
        if (limit != 0 && pick < 14) begin
            return $urandom_range(0, limit - 1);
        end
        if (limit != 0 && pick < 17) begin
            return limit - 1 + $urandom_range(0, 2);
        end
        return $urandom_range(0, 65535);
    endfunction

    function automatic logic [RGB_W-1:0] pick_color();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom_range(0, 24'hFFFFFF);
        endcase
    endfunction

    initial begin
        load_reset_setup();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        set_pacing(PACE_NONE);

        // Writes are disabled out of reset.
        push_pixel(16'd0, 16'd0, 24'hFFFFFF);
        push_pixel(16'd100, 16'd100, 24'h123456);

        // Default 1024x768 frame: corners, first clipped column and row,
        // largest coordinates.
        setup[REG_ENABLE] = 1'b1;
        apply_setup();
        push_pixel(16'd0, 16'd0, 24'h000000);
        push_pixel(16'd1023, 16'd767, 24'hFFFFFF);
        push_pixel(16'd1024, 16'd5, 24'h00FF00);
        push_pixel(16'd5, 16'd768, 24'hFF0000);
        push_pixel(16'hFFFF, 16'hFFFF, 24'h0000FF);
        push_pixel(16'd512, 16'd384, 24'h808080);

        // Oversized frame saturates, widths above 16 saturate, red placed at
        // the top bit, zero pitch, 24-bit pixels.
        setup[REG_FRAME_WIDTH]    = 8191;
        setup[REG_FRAME_HEIGHT]   = 8191;
        setup[REG_ROW_PITCH]      = 0;
        setup[REG_FOUR_BYTE_MODE] = 1'b0;
        setup[REG_RED_LAYOUT]     = {5'd31, 5'd31};
        setup[REG_GREEN_LAYOUT]   = {5'd16, 5'd0};
        setup[REG_BLUE_LAYOUT]    = {5'd1, 5'd16};
        apply_setup();
        push_pixel(16'd4095, 16'd4095, 24'hFFFFFF);
        push_pixel(16'd4096, 16'd0, 24'hFFFFFF);
        push_pixel(16'd0, 16'd4096, 24'hFFFFFF);
        push_pixel(16'd3, 16'd7, 24'hA5C3E1);

        // A zero-width green selects the default layout; the largest pitch
        // makes the offset wrap.
        setup[REG_FRAME_WIDTH]    = MAX_DIM;
        setup[REG_FRAME_HEIGHT]   = MAX_DIM;
        setup[REG_ROW_PITCH]      = 131071;
        setup[REG_FOUR_BYTE_MODE] = 1'b1;
        setup[REG_RED_LAYOUT]     = {5'd8, 5'd16};
        setup[REG_GREEN_LAYOUT]   = {5'd0, 5'd5};
        setup[REG_BLUE_LAYOUT]    = {5'd8, 5'd0};
        apply_setup();
        push_pixel(16'd4095, 16'd4095, 24'hFFFFFF);
        push_pixel(16'd1, 16'd2, 24'h010203);

        // A zero frame width or height clips every pixel.
        setup[REG_FRAME_WIDTH]  = 0;
        setup[REG_FRAME_HEIGHT] = 1;
        apply_setup();
        push_pixel(16'd0, 16'd0, 24'hFFFFFF);
        setup[REG_FRAME_WIDTH]  = 1;
        setup[REG_FRAME_HEIGHT] = 0;
        apply_setup();
        push_pixel(16'd0, 16'd0, 24'hFFFFFF);

        // Single-pixel frame with one-bit channels: rounding on either side
        // of half scale.
        setup[REG_FRAME_HEIGHT] = 1;
        setup[REG_ROW_PITCH]    = 1;
        setup[REG_RED_LAYOUT]   = {5'd1, 5'd0};
        setup[REG_GREEN_LAYOUT] = {5'd1, 5'd1};
        setup[REG_BLUE_LAYOUT]  = {5'd1, 5'd2};
        apply_setup();
        push_pixel(16'd0, 16'd0, 24'h7F7F7F);
        push_pixel(16'd0, 16'd0, 24'h808080);

        // Random register settings, cycling through the pacing modes.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            randomize_setup();
            apply_setup();
            set_pacing(pacing_t'(phase % 4));
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                push_pixel(pick_coord(setup[REG_FRAME_WIDTH]),
                           pick_coord(setup[REG_FRAME_HEIGHT]), pick_color());
            end
        end

        set_pacing(PACE_NONE);
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Checked %0d pixel writes, %0d of them written to the frame and the rest",
                 checked, written);
        $display("clipped or disabled, over %0d register settings and four pacing modes.",
                 settings_applied);
        if (mismatches == 0) begin
            $display("framebuffer_pixel_writer_tb: PASS");
        end else begin
            $display("%0d mismatches found.", mismatches);
            $display("framebuffer_pixel_writer_tb: FAIL");
        end
        $finish;
    end

endmodule
